// File: rtl/linear_map_table_generator_defines.svh
// Assertion macros shared by the linear map table generator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef LINEAR_MAP_TABLE_GENERATOR_DEFINES_SVH
`define LINEAR_MAP_TABLE_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define LMTG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LMTG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LMTG_ASSERT(label, clk, rst_n, prop, msg)
`define LMTG_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/lmtg_pkg.sv
// Types and constants for the linear map table generator.
// No dependencies; used by every module of the block.
package lmtg_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_SRC_LOW       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SRC_HIGH      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DST_START     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_DST_END       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROUNDING_MODE = 3'd4;

  localparam int unsigned ErrW = 35;

  typedef enum logic [1:0] {
    PH_FINISHED = 2'b01,
    PH_RUNNING  = 2'b10
  } phase_e;

  typedef struct packed {
    logic [31:0] src_low;
    logic [31:0] src_high;
    logic [31:0] dst_start;
    logic [31:0] dst_end;
    logic        rounding_mode;
  } cfg_t;

  typedef struct packed {
    logic        entry_written;
    logic [31:0] entry_index;
    logic [31:0] entry_value;
    logic        finished;
  } result_t;

endpackage

// File: rtl/linear_map_table_generator.sv
// Top level of the linear map table generator: config registers, stepping core, result buffer.
// Depends on lmtg_pkg, lmtg_cfg_regs, lmtg_step and lmtg_out_buf.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------------------
//   input   | in        | in_valid_i / in_stall_o  | restart_i
//   result  | out       | out_valid_o / out_stall_i| entry_written_o, entry_index_o,
//           |           |                          | entry_value_o, finished_o
//   config  | in        | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One request is taken per cycle while in_stall_o is low; its result is registered in the buffer.
// Each request is one 35-bit error add/subtract plus the index and value counters.
// Asynchronous active-low reset leaves the block finished; ticks then report finished.
// A two-entry result buffer keeps input accepted while a result waits; in_stall_o rises
// only when both entries are occupied.
module linear_map_table_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lmtg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         entry_written_o,
  output logic [31:0]                  entry_index_o,
  output logic [31:0]                  entry_value_o,
  output logic                         finished_o
);

  lmtg_pkg::cfg_t    cfg;
  lmtg_pkg::result_t step_res;
  lmtg_pkg::result_t out_res;
  logic              buf_full;
  logic              accept;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  lmtg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lmtg_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart_i),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  lmtg_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_i       (step_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign entry_written_o = out_res.entry_written;
  assign entry_index_o   = out_res.entry_index;
  assign entry_value_o   = out_res.entry_value;
  assign finished_o      = out_res.finished;

endmodule

// File: rtl/lmtg_cfg_regs.sv
// Configuration register file of the linear map table generator.
// Depends on lmtg_pkg for the register indexes and the cfg_t bundle.
module lmtg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lmtg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_wdata_i,
  output lmtg_pkg::cfg_t               cfg_o
);

  lmtg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmtg_pkg::CFG_SRC_LOW:       cfg_q.src_low       <= cfg_wdata_i;
        lmtg_pkg::CFG_SRC_HIGH:      cfg_q.src_high      <= cfg_wdata_i;
        lmtg_pkg::CFG_DST_START:     cfg_q.dst_start     <= cfg_wdata_i;
        lmtg_pkg::CFG_DST_END:       cfg_q.dst_end       <= cfg_wdata_i;
        lmtg_pkg::CFG_ROUNDING_MODE: cfg_q.rounding_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lmtg_step.sv
// Error-accumulator stepping core: holds the run state and forms one result per request.
// Depends on lmtg_pkg for the phase encoding and the cfg_t and result_t bundles.
module lmtg_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              restart_i,
  input  lmtg_pkg::cfg_t    cfg_i,
  output lmtg_pkg::result_t res_o
);

  localparam int unsigned ErrW = lmtg_pkg::ErrW;

  lmtg_pkg::phase_e      phase_q, phase_d;
  logic                  wide_q, wide_d;
  logic                  desc_q, desc_d;
  logic [31:0]           idx_q, idx_d;
  logic [31:0]           cur_q, cur_d;
  logic [31:0]           end_q, end_d;
  logic [31:0]           span_q, span_d;
  logic signed [ErrW-1:0] err_q, err_d;
  // Amount taken off the error each tick, and the net change when the error
  // crosses zero (subtract and correction folded into one add).
  logic signed [ErrW-1:0] sub_q, sub_d;
  logic signed [ErrW-1:0] adj_q, adj_d;

  // Restart set-up from the configuration registers.
  logic [31:0]      s_span;
  logic             s_desc;
  logic [31:0]      s_dist;
  logic             s_wide;
  logic [32:0]      s_dspan;
  logic [ErrW-1:0]  s_two_s;
  logic [ErrW-1:0]  s_two_d;
  logic [ErrW-1:0]  s_err0;

  assign s_span  = cfg_i.src_high - cfg_i.src_low;
  assign s_desc  = cfg_i.dst_start > cfg_i.dst_end;
  assign s_dist  = s_desc ? (cfg_i.dst_start - cfg_i.dst_end)
                          : (cfg_i.dst_end - cfg_i.dst_start);
  assign s_wide  = s_span >= s_dist;
  assign s_dspan = {1'b0, s_dist} + {32'd0, cfg_i.rounding_mode & s_wide};
  assign s_two_s = {2'b00, s_span, 1'b0};
  assign s_two_d = {1'b0, s_dspan, 1'b0};
  assign s_err0  = cfg_i.rounding_mode ? s_two_s : {3'b000, s_span};

  // Per-tick arithmetic.
  logic signed [ErrW-1:0] err_sub;
  logic signed [ErrW-1:0] err_adj;
  logic [31:0]            cur_step;

  assign err_sub  = err_q - sub_q;
  assign err_adj  = err_q + adj_q;
  assign cur_step = desc_q ? (cur_q - 32'd1) : (cur_q + 32'd1);

  always_comb begin
    phase_d = phase_q;
    wide_d  = wide_q;
    desc_d  = desc_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    end_d   = end_q;
    span_d  = span_q;
    err_d   = err_q;
    sub_d   = sub_q;
    adj_d   = adj_q;
    res_o   = '0;
    priority if (restart_i) begin
      phase_d = lmtg_pkg::PH_RUNNING;
      wide_d  = s_wide;
      desc_d  = s_desc;
      idx_d   = '0;
      cur_d   = cfg_i.dst_start;
      end_d   = cfg_i.dst_end;
      span_d  = s_span;
      if (s_wide) begin
        err_d = s_err0;
        sub_d = s_two_d;
        adj_d = s_two_s - s_two_d;
      end else begin
        err_d = '0;
        sub_d = s_two_s;
        adj_d = s_two_d - s_two_s;
      end
    end else if (phase_q != lmtg_pkg::PH_RUNNING) begin
      res_o.finished = 1'b1;
    end else if (wide_q) begin
      // One entry per tick; the value steps when the error goes negative.
      res_o.entry_written = 1'b1;
      res_o.entry_index   = idx_q;
      res_o.entry_value   = cur_q;
      if (err_sub[ErrW-1]) begin
        err_d = err_adj;
        cur_d = cur_step;
      end else begin
        err_d = err_sub;
      end
      if (idx_q == span_q) begin
        phase_d        = lmtg_pkg::PH_FINISHED;
        res_o.finished = 1'b1;
      end else begin
        idx_d = idx_q + 32'd1;
      end
    end else begin
      // One destination value per tick; written when the error reaches zero or below.
      if (err_sub[ErrW-1] || (err_sub == '0)) begin
        err_d               = err_adj;
        res_o.entry_written = 1'b1;
        res_o.entry_index   = idx_q;
        res_o.entry_value   = cur_q;
        idx_d               = idx_q + 32'd1;
      end else begin
        err_d = err_sub;
      end
      if (cur_q == end_q) begin
        phase_d        = lmtg_pkg::PH_FINISHED;
        res_o.finished = 1'b1;
      end else begin
        cur_d = cur_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lmtg_pkg::PH_FINISHED;
      wide_q  <= 1'b0;
      desc_q  <= 1'b0;
      idx_q   <= '0;
      cur_q   <= '0;
      end_q   <= '0;
      span_q  <= '0;
      err_q   <= '0;
      sub_q   <= '0;
      adj_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wide_q  <= wide_d;
      desc_q  <= desc_d;
      idx_q   <= idx_d;
      cur_q   <= cur_d;
      end_q   <= end_d;
      span_q  <= span_d;
      err_q   <= err_d;
      sub_q   <= sub_d;
      adj_q   <= adj_d;
    end
  end

endmodule

// File: rtl/lmtg_out_buf.sv
// Two-entry result buffer (output register plus skid register) on the result channel.
// Depends on lmtg_pkg for result_t and on the assertion macro header.
`include "linear_map_table_generator_defines.svh"

module lmtg_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lmtg_pkg::result_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lmtg_pkg::result_t out_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  lmtg_pkg::result_t out_q;
  lmtg_pkg::result_t skid_q;
  logic              pop;

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= push_i;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (push_i) begin
          skid_q <= res_i;
        end
      end else if (push_i) begin
        out_q <= res_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= res_i;
      end else begin
        out_q <= res_i;
      end
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LMTG_ASSERT_NEVER(a_skid_implies_out, clk_i, rst_ni, skid_valid_q && !out_valid_q, "skid entry held while output register is empty")
  `LMTG_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && skid_valid_q, "request pushed into a full result buffer")
  `LMTG_ASSERT(a_skid_refills_out, clk_i, rst_ni, (pop && skid_valid_q) |=> out_valid_q, "skid entry lost on drain")
  `LMTG_ASSERT(a_push_fills_out, clk_i, rst_ni, (push_i && !out_valid_q) |=> out_valid_q, "pushed result not presented")

endmodule
